// ===== hw/rtl/slr_pkg.sv =====
// Shared types, constants and control codes for the slab region layout block.
// Used by slr_ctrl, slr_dp and the top level under hw/rtl; depends on nothing else.
package slr_pkg;

    // Fixed field widths of the item ports.
    localparam int OBJ_W   = 25;
    localparam int LOG_W   = 5;
    localparam int SLABS_W = 19;
    localparam int CFG_W   = 8;

    // Layout constants of the region.
    localparam int HEAD_BYTES       = 64;
    localparam int SLAB_BYTES       = 64;
    localparam int OBJECTS_PER_SLAB = 64;
    localparam int PAGE_SIZE_LOG2   = 16;
    localparam int MAX_REGION_LOG2  = 24;

    // Register file of the APB port.
    localparam int             PADDR_W         = 3;
    localparam int             PDATA_W         = 32;
    localparam int             REG_MIN_SMALL   = 0;
    localparam logic [CFG_W-1:0] MIN_SMALL_RESET = 8'd24;

    // One input transaction.
    typedef struct packed {
        logic [OBJ_W-1:0] object_bytes;
        logic [LOG_W-1:0] region_size_log2;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [OBJ_W-1:0]   objects_in_region;
        logic [SLABS_W-1:0] slabs_in_region;
        logic [OBJ_W-1:0]   wasted_bytes;
        logic [OBJ_W-1:0]   buffer_first_byte;
        logic [OBJ_W-1:0]   buffer_last_byte;
        logic               layout_valid;
    } t_out_item;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_FIT,
        S_EST_DIV,
        S_EST_DIVW,
        S_EST_CEIL,
        S_EST_COST,
        S_EST_AVAIL,
        S_EST_CHECK,
        S_REF_CHECK,
        S_REF_COST,
        S_REF_AVAIL,
        S_REF_DIV,
        S_REF_DIVW,
        S_REF_PROD,
        S_REF_LOST,
        S_FIN_COST,
        S_FIN_FIRST,
        S_EMIT
    } t_state;

    // Operand choice of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_SLAB_BYTES,
        MUL_COUNT_OBJ,
        MUL_SLAB_CAP
    } t_mul_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_item;
        logic     div_start;
        t_mul_src mul_src;
        logic     ld_count_q;
        logic     ld_slabs_q;
        logic     ld_avail;
        logic     ld_lost;
        logic     inc_slabs;
        logic     ld_cap;
        logic     ld_count_min;
        logic     ld_first;
        logic     ld_result;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic fits;
        logic avail_lt_prod;
        logic room_for_slab;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/slr_div.sv =====
// Restoring divider, one quotient bit per cycle, used for every division by
// the object size. Depends on nothing outside this file.
module slr_div #(
    parameter int DW = 25,
    parameter int VW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_busy,
    output logic          o_done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;

    logic [VW:0]      shifted;
    logic [VW:0]      diff;
    logic             ge;
    logic [VW-1:0]    n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
        n_rem   = ge ? diff[VW-1:0] : shifted[VW-1:0];
    end

    // Control: busy while the quotient bits are worked out, then a single done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_W'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

// ===== hw/rtl/slr_ctrl.sv =====
// Controller state machine of the slab region layout block.
// Depends on slr_pkg for the state, command and status types.
module slr_ctrl import slr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_src = MUL_SLAB_BYTES;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_FIT;
                end
            end
            S_FIT: begin
                n_state = i_sts.fits ? S_EST_DIV : S_FIN_COST;
            end
            // Estimate: objects from the available bytes, then slabs for them.
            S_EST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_EST_DIVW;
            end
            S_EST_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_count_q = 1'b1;
                    n_state          = S_EST_CEIL;
                end
            end
            S_EST_CEIL: begin
                o_cmd.ld_slabs_q = 1'b1;
                n_state          = S_EST_COST;
            end
            S_EST_COST: begin
                n_state = S_EST_AVAIL;
            end
            S_EST_AVAIL: begin
                o_cmd.ld_avail = 1'b1;
                o_cmd.mul_src  = MUL_COUNT_OBJ;
                n_state        = S_EST_CHECK;
            end
            S_EST_CHECK: begin
                o_cmd.mul_src = MUL_COUNT_OBJ;
                if (i_sts.avail_lt_prod) begin
                    n_state = S_EST_DIV;
                end else begin
                    o_cmd.ld_lost = 1'b1;
                    n_state       = S_REF_CHECK;
                end
            end
            // Refinement: add one slab while another slab and object still fit.
            S_REF_CHECK: begin
                if (i_sts.room_for_slab) begin
                    o_cmd.inc_slabs = 1'b1;
                    n_state         = S_REF_COST;
                end else begin
                    n_state = S_FIN_COST;
                end
            end
            S_REF_COST: begin
                n_state = S_REF_AVAIL;
            end
            S_REF_AVAIL: begin
                o_cmd.ld_avail = 1'b1;
                o_cmd.mul_src  = MUL_SLAB_CAP;
                n_state        = S_REF_DIV;
            end
            S_REF_DIV: begin
                o_cmd.ld_cap    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_REF_DIVW;
            end
            S_REF_DIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.ld_count_min = 1'b1;
                    n_state            = S_REF_PROD;
                end
            end
            S_REF_PROD: begin
                o_cmd.mul_src = MUL_COUNT_OBJ;
                n_state       = S_REF_LOST;
            end
            S_REF_LOST: begin
                o_cmd.mul_src = MUL_COUNT_OBJ;
                o_cmd.ld_lost = 1'b1;
                n_state       = S_REF_CHECK;
            end
            // Final offsets and hand-over to the output register.
            S_FIN_COST: begin
                n_state = S_FIN_FIRST;
            end
            S_FIN_FIRST: begin
                o_cmd.ld_first = 1'b1;
                o_cmd.mul_src  = MUL_COUNT_OBJ;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.mul_src = MUL_COUNT_OBJ;
                if (i_sts.out_free) begin
                    o_cmd.ld_result = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted transaction always starts with the fit check.
    a_accept_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_FIT))
        else $error("accepted transaction did not enter the fit check");

    // The estimate waits for the divider before moving on.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EST_DIVW && !i_sts.div_done) |=> (r_state == S_EST_DIVW))
        else $error("estimate left the divider wait early");

    // A result is held back while the output register is still occupied.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_sts.out_free) |=> (r_state == S_EMIT))
        else $error("result emitted over an occupied output register");

endmodule

// ===== hw/rtl/slr_dp.sv =====
// Datapath of the slab region layout block: working registers, the shared
// multiplier, the shared divider and the output register. Uses slr_pkg, slr_div.
module slr_dp import slr_pkg::*; #(
    parameter int MAX_LOG2 = MAX_REGION_LOG2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_in_item         i_in_item,
    input  logic [CFG_W-1:0] i_min_small,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    // Region byte counts need MAX_LOG2 + 1 bits; products add an object's width.
    localparam int AW   = MAX_LOG2 + 1;
    localparam int LGW  = $clog2(MAX_LOG2 + 1);
    localparam int PW   = AW + OBJ_W;

    logic [OBJ_W-1:0] r_obj;
    logic [LGW-1:0]   r_lg;
    logic [AW-1:0]    r_usable;
    logic [AW-1:0]    r_avail;
    logic [AW-1:0]    r_count;
    logic [AW-1:0]    r_slabs;
    logic [AW-1:0]    r_lost;
    logic [PW-1:0]    r_cap;
    logic [PW-1:0]    r_prod;
    logic [OBJ_W-1:0] r_first;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [LGW-1:0]   n_lg;
    logic [AW-1:0]    n_region;
    logic [AW-1:0]    n_usable;
    logic [AW-1:0]    n_avail;
    logic [AW-1:0]    mul_a;
    logic [OBJ_W-1:0] mul_b;
    logic [AW-1:0]    div_q;
    logic             div_busy;
    logic             div_done;
    logic             out_take;
    logic             layout_ok;
    t_out_item        n_out;

    // Region size from the saturated logarithm, minus the head.
    always_comb begin
        if (int'(i_in_item.region_size_log2) > MAX_LOG2) begin
            n_lg = LGW'(MAX_LOG2);
        end else begin
            n_lg = LGW'(i_in_item.region_size_log2);
        end
        n_region = AW'(1) << n_lg;
        n_usable = (n_region > AW'(HEAD_BYTES)) ? n_region - AW'(HEAD_BYTES) : '0;
    end

    // Bytes left after the slab descriptors held in the product register.
    assign n_avail = (r_prod > PW'(r_usable)) ? '0 : r_usable - r_prod[AW-1:0];

    // Shared multiplier operand selection.
    always_comb begin
        unique case (i_cmd.mul_src)
            MUL_COUNT_OBJ: begin
                mul_a = r_count;
                mul_b = r_obj;
            end
            MUL_SLAB_CAP: begin
                mul_a = r_slabs;
                mul_b = OBJ_W'(OBJECTS_PER_SLAB);
            end
            default: begin
                mul_a = r_slabs;
                mul_b = OBJ_W'(SLAB_BYTES);
            end
        endcase
    end

    // Product register, loaded every cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    // The divider always works out available bytes over the object size.
    slr_div #(
        .DW (AW),
        .VW (OBJ_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_avail),
        .i_divisor  (r_obj),
        .o_quotient (div_q),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // Working registers of the layout search. The slab count of an estimate
    // is a rounded-up division by the power-of-two objects per slab.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_obj    <= i_in_item.object_bytes;
            r_lg     <= n_lg;
            r_usable <= n_usable;
            r_avail  <= n_usable;
            r_count  <= '0;
            r_slabs  <= '0;
            r_lost   <= '0;
        end else begin
            if (i_cmd.ld_count_q) begin
                r_count <= div_q;
            end else if (i_cmd.ld_count_min) begin
                r_count <= (r_cap < PW'(div_q)) ? r_cap[AW-1:0] : div_q;
            end
            if (i_cmd.ld_slabs_q) begin
                r_slabs <= (r_count + AW'(OBJECTS_PER_SLAB - 1)) / AW'(OBJECTS_PER_SLAB);
            end else if (i_cmd.inc_slabs) begin
                r_slabs <= r_slabs + AW'(1);
            end
            if (i_cmd.ld_avail) begin
                r_avail <= n_avail;
            end
            if (i_cmd.ld_lost) begin
                r_lost <= r_avail - r_prod[AW-1:0];
            end
        end
        if (i_cmd.ld_cap) begin
            r_cap <= r_prod;
        end
        if (i_cmd.ld_first) begin
            r_first <= OBJ_W'(PW'(HEAD_BYTES) + r_prod);
        end
    end

    // Validity of the finished layout.
    assign layout_ok = (r_count != '0) &&
        !((int'(r_lg) < PAGE_SIZE_LOG2) && (r_count < AW'(i_min_small)));

    // Result assembly; the product register holds objects times object size.
    always_comb begin
        n_out.objects_in_region = OBJ_W'(r_count);
        n_out.slabs_in_region   = SLABS_W'(r_slabs);
        n_out.wasted_bytes      = OBJ_W'(r_lost);
        n_out.buffer_first_byte = r_first;
        n_out.buffer_last_byte  = r_first + r_prod[OBJ_W-1:0];
        n_out.layout_valid      = layout_ok;
    end

    // Output register.
    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_result) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_result) begin
            r_out <= n_out;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_sts.div_done      = div_done;
        o_sts.fits          = (r_obj != '0) && (PW'(r_usable) >= PW'(r_obj));
        o_sts.avail_lt_prod = (PW'(r_avail) < r_prod);
        o_sts.room_for_slab = (PW'(r_lost) >= PW'(r_obj) + PW'(SLAB_BYTES));
        o_sts.out_free      = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The divider is never restarted while a division is still running.
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    // A result is only loaded when the previous one has gone or is going.
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_result && r_out_valid) |-> !i_out_stall)
        else $error("pending result overwritten");

    // A taken result with no new one behind it leaves the register empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !i_cmd.ld_result) |=> !r_out_valid)
        else $error("output register did not drain");

endmodule

// ===== hw/rtl/slab_region_layout_unit.sv =====
// Top level of the slab region layout block: APB register, controller, datapath.
// Depends on slr_pkg, slr_ctrl, slr_dp and slr_div.
//
//   Channel   Direction  Handshake              Payload
//   in        to block   i_in_valid/o_in_stall  t_in_item  (object size, region log2)
//   out       from block o_out_valid/i_out_stall t_out_item (layout of the region)
//   apb       to block   psel/penable/pready    min_small_objects at byte address 0
//
// One transaction at a time. A transaction runs one or two estimate rounds, then
// adds slabs one at a time in refinement. Each round waits on the single restoring
// divider, one quotient bit per cycle; an object that does not fit skips straight
// to the final offsets.
// Reset is synchronous and active low; it restores min_small_objects to 24.
// The next transaction is taken while a result still waits in the output register;
// a stalled output only holds the block once a second result is ready.
module slab_region_layout_unit import slr_pkg::*; #(
    parameter int MAX_REGION_LOG2 = slr_pkg::MAX_REGION_LOG2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0] r_min_small;
    logic             reg_hit;
    t_cmd             cmd;
    t_sts             sts;

    // Register decode: one word register at the lowest address.
    assign reg_hit = (paddr[PADDR_W-1:2] == (PADDR_W - 2)'(REG_MIN_SMALL));
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_small <= MIN_SMALL_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_min_small <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = reg_hit ? PDATA_W'(r_min_small) : '0;

    slr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    slr_dp #(
        .MAX_LOG2 (MAX_REGION_LOG2)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .i_min_small (r_min_small),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sv/layout_checker.sv =====
// Scoreboard for the slab region layout block: works out the layout of every
// accepted request and checks each result transaction against the oldest one due.
// Depends on slr_pkg for the item types, field widths and layout constants.
module layout_checker import slr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam logic [PADDR_W-1:0] MIN_SMALL_ADDR = PADDR_W'(4 * REG_MIN_SMALL);
    localparam int                 REPORT_LIMIT   = 10;

    // A request kept together with the layout it must produce.
    typedef struct packed {
        t_in_item  request;
        t_out_item layout;
    } t_awaited;

    t_awaited         awaited_q[$];
    logic [CFG_W-1:0] min_small_q;
    int               mismatches = 0;
    int               checked    = 0;

    // Bytes left for objects once the given number of slab descriptors is paid for.
    function automatic longint unsigned bytes_after_slabs(input longint unsigned usable,
                                                          input longint unsigned slabs);
        longint unsigned cost;
        cost = slabs * SLAB_BYTES;
        return (cost > usable) ? 64'd0 : usable - cost;
    endfunction

    // Full layout of one region: estimate by division, then grow the slab count.
    function automatic t_out_item compute_layout(input t_in_item req,
                                                 input logic [CFG_W-1:0] min_small);
        longint unsigned obj, lg, usable, avail, count, slabs, lost, cap, fit;
        longint unsigned first, last;
        logic            usable_ok;
        t_out_item       res;
        obj   = req.object_bytes;
        lg    = req.region_size_log2;
        count = 0;
        slabs = 0;
        lost  = 0;
        if (lg > MAX_REGION_LOG2)
            lg = MAX_REGION_LOG2;
        usable = ((64'd1 << lg) > HEAD_BYTES) ? (64'd1 << lg) - HEAD_BYTES : 64'd0;

        if (obj != 0 && usable >= obj) begin
            // The estimate settles within two rounds; an overshoot leaves nothing.
            avail = usable;
            do begin
                count = avail / obj;
                slabs = (count + OBJECTS_PER_SLAB - 1) / OBJECTS_PER_SLAB;
                avail = bytes_after_slabs(usable, slabs);
            end while (avail < count * obj);

            // Add slabs while one more descriptor and one more object would fit.
            lost = bytes_after_slabs(usable, slabs) - count * obj;
            while (lost >= obj + SLAB_BYTES) begin
                slabs++;
                cap   = slabs * OBJECTS_PER_SLAB;
                fit   = bytes_after_slabs(usable, slabs) / obj;
                count = (cap < fit) ? cap : fit;
                lost  = bytes_after_slabs(usable, slabs) - count * obj;
            end
        end

        first     = HEAD_BYTES + slabs * SLAB_BYTES;
        last      = first + count * obj;
        usable_ok = (count != 0);
        if (lg < PAGE_SIZE_LOG2 && count < min_small)
            usable_ok = 1'b0;

        res.objects_in_region = count[OBJ_W-1:0];
        res.slabs_in_region   = slabs[SLABS_W-1:0];
        res.wasted_bytes      = lost[OBJ_W-1:0];
        res.buffer_first_byte = first[OBJ_W-1:0];
        res.buffer_last_byte  = last[OBJ_W-1:0];
        res.layout_valid      = usable_ok;
        return res;
    endfunction

    // Track the register, queue predictions and compare results on every edge.
    always @(posedge i_clk) begin
        t_awaited  fresh;
        t_awaited  head;
        t_out_item got;
        logic      bad;
        if (!i_rst_n) begin
            min_small_q <= MIN_SMALL_RESET;
            awaited_q.delete();
        end else begin
            // A register write applies to requests from the following cycle on.
            if (psel && penable && pwrite && pready && paddr == MIN_SMALL_ADDR)
                min_small_q <= pwdata[CFG_W-1:0];

            if (i_in_valid && !i_in_stall) begin
                fresh.request = i_in_item;
                fresh.layout  = compute_layout(i_in_item, min_small_q);
                awaited_q.insert(awaited_q.size(), fresh);
            end

            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (awaited_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result, nothing outstanding: %s%0d slabs=%0d",
                                 "objects=", got.objects_in_region,
                                 got.slabs_in_region);
                end else begin
                    head = awaited_q.pop_front();
                    checked++;
                    bad = (got.objects_in_region !== head.layout.objects_in_region)
                        | (got.slabs_in_region   !== head.layout.slabs_in_region)
                        | (got.wasted_bytes      !== head.layout.wasted_bytes)
                        | (got.buffer_first_byte !== head.layout.buffer_first_byte)
                        | (got.buffer_last_byte  !== head.layout.buffer_last_byte)
                        | (got.layout_valid      !== head.layout.layout_valid);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("layout mismatch for object_bytes=%0d region_log2=%0d",
                                     head.request.object_bytes,
                                     head.request.region_size_log2);
                            $display("  expected objects=%0d slabs=%0d wasted=%0d %s%0d %s%0d %s%b",
                                     head.layout.objects_in_region,
                                     head.layout.slabs_in_region,
                                     head.layout.wasted_bytes,
                                     "first=", head.layout.buffer_first_byte,
                                     "last=", head.layout.buffer_last_byte,
                                     "valid=", head.layout.layout_valid);
                            $display("  actual   objects=%0d slabs=%0d wasted=%0d %s%0d %s%0d %s%b",
                                     got.objects_in_region, got.slabs_in_region,
                                     got.wasted_bytes,
                                     "first=", got.buffer_first_byte,
                                     "last=", got.buffer_last_byte,
                                     "valid=", got.layout_valid);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the slab region layout testbench: clock, reset, request and register
// stimulus, receiver back-pressure, watchdog and the final verdict.
// Depends on slr_pkg, slab_region_layout_unit and layout_checker.
module testbench;
    import slr_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int LONG_HOLD       = 1500;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int SETTLE_CYCLES   = 100;
    localparam logic [PADDR_W-1:0] MIN_SMALL_ADDR = PADDR_W'(4 * REG_MIN_SMALL);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_item;
    logic               out_valid;
    logic               out_stall;
    t_out_item          out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int   fail_count;
    int   pending;
    int   checked;
    int   in_idle_pct;
    int   out_stall_pct;
    logic hold_toggle;
    int   quiet_cycles = 0;
    int   requests_sent;
    int   settings_written;

    slab_region_layout_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    layout_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Free-running clock with a period of two time units.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold each time the toggle flips.
    initial begin : receiver
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    // Count cycles in which no transaction of any kind is accepted.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_in_item layout_request(input logic [OBJ_W-1:0] obj,
                                                input logic [LOG_W-1:0] lg);
        t_in_item req;
        req.object_bytes     = obj;
        req.region_size_log2 = lg;
        return req;
    endfunction

    // Random request. Tiny objects in big regions take many refinement rounds,
    // so the object size is kept above a floor that grows with the region.
    function automatic t_in_item pick_request();
        t_in_item         req;
        int               roll;
        int               lg_eff;
        int               k;
        logic [OBJ_W-1:0] obj;
        logic [OBJ_W-1:0] floor_obj;
        roll = $urandom_range(99);
        if (roll < 8)
            req.region_size_log2 = LOG_W'($urandom_range(31));
        else if (roll < 70)
            req.region_size_log2 = LOG_W'($urandom_range(12, 16));
        else
            req.region_size_log2 = LOG_W'($urandom_range(17, 24));
        lg_eff = (req.region_size_log2 > MAX_REGION_LOG2) ? MAX_REGION_LOG2
                                                           : req.region_size_log2;

        roll = $urandom_range(99);
        if (roll < 2) begin
            obj = '0;
        end else if (roll < 10) begin
            obj = OBJ_W'($urandom);
        end else begin
            k   = (roll < 85) ? $urandom_range(lg_eff) : $urandom_range(OBJ_W - 1);
            obj = (OBJ_W'(1) << k) | (OBJ_W'($urandom) & ((OBJ_W'(1) << k) - OBJ_W'(1)));
        end
        floor_obj = OBJ_W'(1) << ((lg_eff > 12) ? (lg_eff - 12) / 3 : 0);
        if (obj != 0 && obj < floor_obj)
            obj = obj + floor_obj;
        req.object_bytes = obj;
        return req;
    endfunction

    // Offer one request, idling first at random, and return once it is accepted.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted result has been checked.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Register write: a setup phase, then access until pready.
    task automatic set_min_small(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MIN_SMALL_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    initial begin : stimulus
        int               idle_plan [4];
        int               stall_plan [4];
        logic [CFG_W-1:0] min_plan [4];
        idle_plan  = '{0, 57, 0, 36};
        stall_plan = '{0, 0, 57, 36};
        min_plan   = '{8'd1, 8'd255, CFG_W'($urandom_range(2, 254)),
                       CFG_W'($urandom_range(1, 255))};

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_item          = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_idle_pct      = 0;
        out_stall_pct    = 0;
        hold_toggle      = 1'b0;
        requests_sent    = 0;
        settings_written = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset value of min_small_objects.
        send_request(layout_request(25'd1, 5'd12));       // estimate overshoots
        send_request(layout_request(25'd0, 5'd16));       // zero-sized object
        send_request(layout_request(25'd1, 5'd0));        // region below the head
        send_request(layout_request(25'd1, 5'd6));        // region equal to the head
        send_request(layout_request(25'd1, 5'd7));
        send_request(layout_request(25'd64, 5'd7));
        send_request(layout_request(25'd65, 5'd7));       // object just too big
        send_request(layout_request(25'd24, 5'd11));
        send_request(layout_request(25'd168, 5'd12));     // one short of the minimum
        send_request(layout_request(25'd165, 5'd12));     // exactly the minimum
        send_request(layout_request(25'd4032, 5'd12));
        send_request(layout_request(25'd4033, 5'd12));
        send_request(layout_request(25'd100, 5'd15));
        send_request(layout_request(25'd100, 5'd16));     // first full-page region
        send_request(layout_request(25'd3, 5'd13));
        send_request(layout_request(25'd2, 5'd15));
        send_request(layout_request(25'd1, 5'd14));
        send_request(layout_request(25'd1000, 5'd20));
        send_request(layout_request(25'd12345, 5'd22));
        send_request(layout_request(25'd16, 5'd24));
        send_request(layout_request(25'd16, 5'd31));      // oversized region saturates
        send_request(layout_request(25'h0800000, 5'd24));
        send_request(layout_request(25'h1000000, 5'd24)); // object as big as the largest region, no room
        send_request(layout_request(25'h1FFFFFF, 5'd31));
        send_request(layout_request(25'h0AAAAAA, 5'd25));

        // Random phases, each under its own register value and handshake pressure.
        for (int ph = 0; ph < 4; ph++) begin
            wait_for_results();
            set_min_small(min_plan[ph]);
            in_idle_pct   <= idle_plan[ph];
            out_stall_pct <= stall_plan[ph];
            if (ph == 2)
                hold_toggle <= ~hold_toggle;
            repeat (ITEMS_PER_PHASE)
                send_request(pick_request());
        end

        // Back to the reset value for a short closing burst.
        wait_for_results();
        set_min_small(MIN_SMALL_RESET);
        in_idle_pct   <= 0;
        out_stall_pct <= 0;
        repeat (30)
            send_request(pick_request());

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Summary: %0d layout requests sent, %0d results checked, %0d register writes,",
                 requests_sent, checked, settings_written);
        $display("  over directed corners, idle and stall phases and one long output hold.");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/slr_pkg.sv
hw/rtl/slr_div.sv
hw/rtl/slr_ctrl.sv
hw/rtl/slr_dp.sv
hw/rtl/slab_region_layout_unit.sv
tb/sv/layout_checker.sv
tb/sv/testbench.sv
